// ===== src/md5_pkg.sv =====
// Package: MD5 payload types, constants and round helper functions.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_index;
        logic        last_of_run;
    } md5_out_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    function automatic logic [31:0] round_add(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_by(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0:    g = r[3:0];
            2'd1:    g = 4'(5 * r[3:0] + 1);
            2'd2:    g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== src/md5_message_digest.sv =====
// Top level: MD5 digest engine over a byte stream.
//
// Input channel (in_valid/in_stall, payload in_data): one message byte per
// transfer, byte_present qualifying data_byte; message_end closes the message.
// Output channel (out_valid/out_stall, payload out_data): two transfers per
// message, digest half 0 then half 1 with last_of_run set.
// Bytes are packed into a 16-word block memory with a registered read port.
// The input takes a byte while idle; the 64th byte of a block starts a
// compression: a load step, 64 rounds and the chaining add, one round
// per cycle bound by the block-memory read port; input stalls meanwhile.
// An end transfer writes the pad byte, zero-fills one word per cycle, writes
// the length words, runs one or two compressions, then presents the digest.
// While the receiver stalls the digest holds and no transfer is taken.
// Reset restores the initial chaining words and a zero bit count; block
// memory content is undefined until written, and no clearing pass is needed.
module md5_message_digest
    import md5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  md5_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output md5_out_t out_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT0 = 3'd5;
    localparam logic [2:0] ST_OUT1 = 3'd6;

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [3:0]  pw_reg, pw_next;
    logic        fin_reg, fin_next;
    logic        second_reg, second_next;

    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  wr_lane;
    logic [3:0]  rd_addr;
    logic [31:0] b_new;
    logic        accept;
    logic [5:0]  pos;

    assign pos      = len_reg[8:3];
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    md5_round u_round (
        .rnd   (rnd_reg[5:0] - 6'd1),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (rd_data_reg),
        .b_new (b_new)
    );

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        rnd_next    = rnd_reg;
        pw_next     = pw_reg;
        fin_next    = fin_reg;
        second_next = second_reg;
        wr_en       = 1'b0;
        wr_addr     = pos[5:2];
        wr_data     = {4{in_data.data_byte}};
        wr_lane     = 4'b0001 << pos[1:0];
        rd_addr     = msg_index(rnd_reg[5:0]);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.byte_present)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 64'd8;
                    end
                    if (in_data.byte_present && pos == 6'd63)
                    begin
                        fin_next   = 1'b0;
                        second_next = in_data.message_end;
                        rnd_next   = 7'd0;
                        state_next = ST_RUN;
                    end
                    else if (in_data.message_end)
                    begin
                        pw_next    = 4'(({1'b0, pos} + 7'(in_data.byte_present)) >> 2);
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // first pass writes pad byte and clears upper lanes of its word
                wr_en   = 1'b1;
                wr_addr = pw_reg;
                if (pw_reg == pos[5:2] && fin_reg == 1'b0 && second_reg == 1'b0)
                begin
                    wr_data = 32'(PAD_BYTE) << {pos[1:0], 3'b000};
                    wr_lane = 4'b1111 << pos[1:0];
                end
                else
                begin
                    wr_data = '0;
                    wr_lane = 4'b1111;
                end
                pw_next = pw_reg + 4'd1;
                fin_next = 1'b1;
                if (pw_reg == 4'd15)
                begin
                    fin_next    = 1'b1;
                    second_next = 1'b1;
                    rnd_next    = 7'd0;
                    state_next  = ST_RUN;
                end
                else if (pw_reg == 4'd13 && (pos < LEN_POS || second_reg))
                begin
                    pw_next    = 4'd14;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                wr_en   = 1'b1;
                wr_addr = pw_reg;
                wr_lane = 4'b1111;
                wr_data = pw_reg[0] ? len_reg[63:32] : len_reg[31:0];
                pw_next = pw_reg + 4'd1;
                if (pw_reg[0])
                begin
                    second_next = 1'b0;
                    fin_next    = 1'b1;
                    rnd_next    = 7'd0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd64)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!fin_reg)
                begin
                    if (second_reg)
                    begin
                        // message ended on a full block: pad into a fresh block
                        pw_next     = 4'd0;
                        second_next = 1'b0;
                        state_next  = ST_PAD;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    // length goes into a fresh all-zero block
                    pw_next     = 4'd0;
                    state_next  = ST_PAD;
                end
                else
                    state_next = ST_OUT0;
            end
            ST_OUT0:
            begin
                if (!out_stall)
                    state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                if (!out_stall)
                begin
                    len_next   = '0;
                    fin_next   = 1'b0;
                    second_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (wr_lane[i])
                    mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
            end
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            rnd_reg    <= '0;
            pw_reg     <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            h_reg[0]   <= INIT_A;
            h_reg[1]   <= INIT_B;
            h_reg[2]   <= INIT_C;
            h_reg[3]   <= INIT_D;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            rnd_reg    <= rnd_next;
            pw_reg     <= pw_next;
            fin_reg    <= fin_next;
            second_reg <= second_next;
            if (state_reg == ST_ADD)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
            if (state_reg == ST_OUT1 && !out_stall)
            begin
                h_reg[0] <= INIT_A;
                h_reg[1] <= INIT_B;
                h_reg[2] <= INIT_C;
                h_reg[3] <= INIT_D;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN)
        begin
            if (rnd_reg == 7'd0)
            begin
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
            end
            else
            begin
                a_reg <= d_reg;
                b_reg <= b_new;
                c_reg <= b_reg;
                d_reg <= c_reg;
            end
        end
    end

    assign out_valid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign out_data.half_index  = (state_reg == ST_OUT1);
    assign out_data.last_of_run = (state_reg == ST_OUT1);
    assign out_data.digest_half = (state_reg == ST_OUT1)
        ? {bswap32(h_reg[2]), bswap32(h_reg[3])}
        : {bswap32(h_reg[0]), bswap32(h_reg[1])};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("digest changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> in_stall)
        else $error("input taken during compression");
    a_half_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT1 |-> $past(state_reg) == ST_OUT0 || $past(state_reg) == ST_OUT1)
        else $error("second half without first");
endmodule

// ===== src/md5_round.sv =====
// One MD5 round step: working-word update from one message word.
module md5_round
    import md5_pkg::*;
(
    input  logic [5:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    output logic [31:0] b_new
);
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  sh;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        sum   = a + f + round_add(rnd) + m;
        sh    = rot_by(rnd);
        b_new = b + ((sum << sh) | (sum >> (6'd32 - {1'b0, sh})));
    end
endmodule

// ===== bench/md5_message_digest_test.sv =====
// Testbench for md5_message_digest: directed table and random messages checked against a predictor.
`timescale 1ns / 100ps
module md5_message_digest_test
    import md5_pkg::*;
;

    typedef struct {
        md5_in_t     item;
        logic        known;
        logic [63:0] half0;
        logic [63:0] half1;
    } table_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    md5_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    md5_out_t out_data;

    logic [31:0] chain [4];
    logic [31:0] block [16];
    logic [63:0] msg_bits;
    md5_out_t    digest_queue [$];
    int          failures = 0;
    int          digests_seen = 0;
    int          items_sent = 0;
    longint      cycle_count = 0;
    bit          hold_off = 1'b0;
    table_row_t  rows [$];

    md5_message_digest dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("timeout at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    task automatic reset_digest_state();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        foreach (block[i]) block[i] = '0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        logic [31:0] sine_table [64];
        int          shifts [16];
        logic [31:0] a, b, c, d, f, t;
        int          g;
        sine_table = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                f = (b & c) | (~b & d);
                g = r;
            end
            else if (r < 32)
            begin
                f = (d & b) | (~d & c);
                g = (5 * r + 1) % 16;
            end
            else if (r < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * r + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * r) % 16;
            end
            t = d;
            d = c;
            c = b;
            b = b + rotl(a + f + sine_table[r] + block[g], shifts[(r / 16) * 4 + r % 4]);
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic store_byte(input int pos, input logic [7:0] value);
        block[pos / 4][(pos % 4) * 8 +: 8] = value;
    endtask

    task automatic predict_digest(input md5_in_t item);
        int       pos;
        md5_out_t res;
        if (item.byte_present)
        begin
            pos = int'(msg_bits[8:3]);
            store_byte(pos, item.data_byte);
            msg_bits += 64'd8;
            if (pos == 63)
                compress_block();
        end
        if (item.message_end)
        begin
            pos = int'(msg_bits[8:3]);
            store_byte(pos, PAD_BYTE);
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    store_byte(pos, 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                store_byte(pos, 8'h00);
                pos++;
            end
            block[14] = msg_bits[31:0];
            block[15] = msg_bits[63:32];
            compress_block();
            res.digest_half = {swap_bytes(chain[0]), swap_bytes(chain[1])};
            res.half_index = 1'b0;
            res.last_of_run = 1'b0;
            digest_queue = {digest_queue, res};
            res.digest_half = {swap_bytes(chain[2]), swap_bytes(chain[3])};
            res.half_index = 1'b1;
            res.last_of_run = 1'b1;
            digest_queue = {digest_queue, res};
            reset_digest_state();
        end
    endtask

    task automatic send_item(input md5_in_t item);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        in_data = item;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_digest(item);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic add_row(input md5_in_t item, input logic known,
                           input logic [63:0] h0, input logic [63:0] h1);
        table_row_t row;
        row.item = item;
        row.known = known;
        row.half0 = h0;
        row.half1 = h1;
        rows = {rows, row};
    endtask

    task automatic send_message(input int len);
        md5_in_t item;
        for (int i = 0; i < len; i++)
        begin
            item.data_byte = 8'($urandom_range(0, 255));
            item.byte_present = 1'b1;
            item.message_end = (i == len - 1) && ($urandom_range(0, 1) == 1);
            if ($urandom_range(0, 15) == 0)
            begin
                item.byte_present = 1'b0;
                item.message_end = 1'b0;
                send_item(item);
                item.byte_present = 1'b1;
            end
            send_item(item);
            if (item.message_end)
                return;
        end
        item.data_byte = 8'($urandom_range(0, 255));
        item.byte_present = 1'b0;
        item.message_end = 1'b1;
        send_item(item);
    endtask

    // receiver: random stall per transfer, one long hold-off
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        md5_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, out_data);
                failures++;
            end
            else
            begin
                want = digest_queue.pop_front();
                digests_seen++;
                if (out_data.digest_half !== want.digest_half)
                begin
                    $display("%0t: digest_half expected %h actual %h", $time,
                             want.digest_half, out_data.digest_half);
                    failures++;
                end
                if (out_data.half_index !== want.half_index)
                begin
                    $display("%0t: half_index expected %b actual %b", $time,
                             want.half_index, out_data.half_index);
                    failures++;
                end
                if (out_data.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last_of_run, out_data.last_of_run);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        md5_out_t k0, k1;
        int       len;
        reset_digest_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty message, then "a", "abc" with an ignored item inside, bytes 00 and ff
        add_row('{8'hff, 1'b0, 1'b1}, 1'b1, 64'hd41d8cd98f00b204, 64'he9800998ecf8427e);
        add_row('{8'h61, 1'b1, 1'b1}, 1'b1, 64'h0cc175b9c0f1b6a8, 64'h31c399e269772661);
        add_row('{8'h61, 1'b1, 1'b0}, 1'b0, '0, '0);
        add_row('{8'h62, 1'b1, 1'b0}, 1'b0, '0, '0);
        add_row('{8'h00, 1'b0, 1'b0}, 1'b0, '0, '0);
        add_row('{8'h63, 1'b1, 1'b0}, 1'b0, '0, '0);
        add_row('{8'h00, 1'b0, 1'b1}, 1'b1, 64'h900150983cd24fb0, 64'hd6963f7d28e17f72);
        add_row('{8'h00, 1'b1, 1'b0}, 1'b0, '0, '0);
        add_row('{8'hff, 1'b1, 1'b1}, 1'b0, '0, '0);
        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].known)
            begin
                k0 = digest_queue[digest_queue.size() - 2];
                k1 = digest_queue[digest_queue.size() - 1];
                if (k0.digest_half !== rows[i].half0 || k1.digest_half !== rows[i].half1)
                begin
                    $display("%0t: table digest expected %h%h predicted %h%h", $time,
                             rows[i].half0, rows[i].half1, k0.digest_half, k1.digest_half);
                    failures++;
                end
            end
        end

        // padding boundaries: 55, 56, 63, 64 byte messages
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);

        // receiver holds off while bytes keep coming
        hold_off = 1'b1;
        send_message(3);
        send_message(2);
        send_message(130);

        // sender waits until all digests are back
        while (digest_queue.size() != 0)
            @(negedge clk);

        while (items_sent < 700)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
            send_message(len);
        end

        while (digest_queue.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("sent %0d items; checked %0d digest halves including padding boundaries",
                 items_sent, digests_seen);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
